### hw/rtl/columnar_transposition_codec_macros.svh
// ----------------------------------------------------------------------------
// Columnar transposition codec assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLUMNAR_TRANSPOSITION_CODEC_MACROS_SVH
`define COLUMNAR_TRANSPOSITION_CODEC_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define CTC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("columnar_transposition_codec: assertion failed");

// antecedent holds, consequent holds in the next cycle
`define CTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("columnar_transposition_codec: assertion failed");

`endif

### hw/rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Types and constants shared by the columnar transposition codec.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int RW     = 7;  // rail count width
  localparam int WW     = 8;  // pointer arithmetic width (index + rails)
  localparam int DIV_SW = 3;  // divider step counter width

  localparam logic [0:0] CFG_RAIL_COUNT   = 1'b0;
  localparam logic [0:0] CFG_DECRYPT_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } ctc_state_e;

  typedef struct packed {
    logic          done;
    logic [RW-1:0] quot;
    logic [RW-1:0] rem;
  } div_res_t;

endpackage

### hw/rtl/ctc_ram.sv
// ----------------------------------------------------------------------------
// ctc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ctc_div.sv
// ----------------------------------------------------------------------------
// ctc_div
// Restoring divider, one quotient bit per cycle; gives the full-column count
// and the number of rows holding an extra byte.
// ----------------------------------------------------------------------------
module ctc_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ctc_pkg::RW-1:0] dividend_i,
  input  logic [ctc_pkg::RW-1:0] divisor_i,
  output ctc_pkg::div_res_t      res_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [ctc_pkg::DIV_SW-1:0] step_q, step_d;
  logic [ctc_pkg::RW-1:0]     dvd_q, dvd_d;
  logic [ctc_pkg::RW-1:0]     rem_q, rem_d;
  logic [ctc_pkg::RW-1:0]     dsr_q, dsr_d;
  logic [ctc_pkg::RW:0]       trial;
  logic                       ge;

  assign trial = {rem_q, dvd_q[ctc_pkg::RW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = ctc_pkg::DIV_SW'(ctc_pkg::RW - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[ctc_pkg::RW-2:0], ge};
      rem_d = ge ? ctc_pkg::RW'(trial - {1'b0, dsr_q}) : ctc_pkg::RW'(trial);
      step_d = step_q - ctc_pkg::DIV_SW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dvd_q;
  assign res_o.rem  = rem_q;

endmodule

### hw/rtl/columnar_transposition_codec.sv
// Load: one input beat per cycle, bytes up to MAX_LEN written to the message RAM.
// After the last input beat the 7-step divider runs, then the first RAM read issues.
// Emission: one RAM read outstanding at a time; each beat is held until taken.
// Input is taken again once the final read of a run is issued.
// Reset: async, active low; counters, flags and handshakes clear, RAM is not cleared.
// ----------------------------------------------------------------------------
// columnar_transposition_codec
// Buffers a message, then streams it out in columnar transposition order,
// encrypting or decrypting with a configured number of rows.
// ----------------------------------------------------------------------------
module columnar_transposition_codec #(
  parameter int MAX_LEN = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [ctc_pkg::RW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_message_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o,
  output logic                   overflow_o
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  ctc_pkg::ctc_state_e    state_q, state_d;
  logic [ctc_pkg::RW-1:0] rail_q;
  logic                   dmode_q;
  logic [CW-1:0]          count_q;
  logic                   dropped_q;
  logic [CW-1:0]          len_q;
  logic [ctc_pkg::RW-1:0] rows_q;
  logic                   mode_q;
  logic                   run_ovf_q;
  logic [ctc_pkg::RW-1:0] row_q, row_d;
  logic [ctc_pkg::RW-1:0] col_q, col_d;
  logic [ctc_pkg::WW-1:0] ptr_q, ptr_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   pend_q, pend_last_q, pend_ovf_q;
  logic                   out_valid_q, out_last_q, out_ovf_q;
  logic [7:0]             out_byte_q;

  logic                   in_fire, full, issue, run_last, row_lt;
  logic [CW-1:0]          len_next;
  logic [ctc_pkg::RW-1:0] rows_next;
  logic [ctc_pkg::WW-1:0] enc_step, len_w;
  logic [7:0]             rdata;
  ctc_pkg::div_res_t      div_res;

  assign in_ready_o = (state_q == ctc_pkg::ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(MAX_LEN));
  assign len_next   = full ? count_q : count_q + CW'(1);
  assign rows_next  = (rail_q == '0) ? ctc_pkg::RW'(1) : rail_q;

  assign issue    = (state_q == ctc_pkg::ST_EMIT) && !pend_q && (!out_valid_q || out_ready_i);
  assign run_last = (cnt_q == len_q - CW'(1));
  assign len_w    = ctc_pkg::WW'(len_q);
  assign enc_step = ptr_q + ctc_pkg::WW'(rows_q);
  assign row_lt   = row_q < div_res.rem;

  ctc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && end_of_message_i),
    .dividend_i (ctc_pkg::RW'(len_next)),
    .divisor_i  (rows_next),
    .res_o      (div_res)
  );

  ctc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && !full),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (issue),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // encrypt walks rows by stride R; decrypt steps down a column by row length
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    case (state_q)
      ctc_pkg::ST_LOAD: begin
        if (in_fire && end_of_message_i) begin
          state_d = ctc_pkg::ST_DIV;
        end
      end
      ctc_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_d = ctc_pkg::ST_EMIT;
          row_d   = '0;
          col_d   = '0;
          ptr_d   = '0;
          cnt_d   = '0;
        end
      end
      ctc_pkg::ST_EMIT: begin
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
          if (run_last) begin
            state_d = ctc_pkg::ST_LOAD;
          end
          if (!mode_q) begin
            if (enc_step < len_w) begin
              ptr_d = enc_step;
            end else begin
              row_d = row_q + ctc_pkg::RW'(1);
              ptr_d = ctc_pkg::WW'(row_q) + ctc_pkg::WW'(1);
            end
          end else begin
            if ((row_q + ctc_pkg::RW'(1)) == rows_q) begin
              row_d = '0;
              col_d = col_q + ctc_pkg::RW'(1);
              ptr_d = ctc_pkg::WW'(col_q) + ctc_pkg::WW'(1);
            end else begin
              row_d = row_q + ctc_pkg::RW'(1);
              ptr_d = ptr_q + ctc_pkg::WW'(div_res.quot) + ctc_pkg::WW'(row_lt);
            end
          end
        end
      end
      default: state_d = ctc_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctc_pkg::ST_LOAD;
      row_q   <= '0;
      col_q   <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q  <= ctc_pkg::RW'(1);
      dmode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ctc_pkg::CFG_RAIL_COUNT:   rail_q  <= cfg_wdata_i;
        ctc_pkg::CFG_DECRYPT_MODE: dmode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      len_q     <= '0;
      rows_q    <= ctc_pkg::RW'(1);
      mode_q    <= 1'b0;
      run_ovf_q <= 1'b0;
    end else if (in_fire) begin
      if (end_of_message_i) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
        len_q     <= len_next;
        rows_q    <= rows_next;
        mode_q    <= dmode_q;
        run_ovf_q <= dropped_q || full;
      end else if (full) begin
        dropped_q <= 1'b1;
      end else begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_last_q <= run_last;
      pend_ovf_q  <= run_ovf_q;
    end
    if (pend_q) begin
      out_byte_q <= rdata;
      out_last_q <= pend_last_q;
      out_ovf_q  <= pend_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

endmodule

### hw/rtl/ctc_checker.sv
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level checks on the columnar transposition codec, bound to the top.
// ----------------------------------------------------------------------------
`include "columnar_transposition_codec_macros.svh"

module ctc_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [0:0]             cfg_index_i,
  input logic [ctc_pkg::RW-1:0] cfg_wdata_i,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [7:0]             data_byte_i,
  input logic                   end_of_message_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [7:0]             out_byte_o,
  input logic                   out_last_o,
  input logic                   overflow_o
);

  `CTC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `CTC_ASSERT_SAME(a_in_only_at_run_tail, in_ready_o && out_valid_o, out_last_o)
  `CTC_ASSERT_NEXT(a_last_in_closes_load, in_valid_i && in_ready_o && end_of_message_i, !in_ready_o)
  `CTC_ASSERT_NEXT(a_gap_after_run, out_valid_o && out_ready_i && out_last_o, !out_valid_o)

endmodule

bind columnar_transposition_codec ctc_checker u_ctc_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Columnar transposition codec testbench
// Streams messages through the codec under several row counts and both
// directions, with bursty input and a stalling receiver, and compares every
// output beat against a software transposition of the same message.
// ----------------------------------------------------------------------------
localparam int MSG_DEPTH = 64;

typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       ovf;
} codec_beat_t;

class transposition_checker;
  logic [7:0]  msg_buf [MSG_DEPTH];
  int unsigned held;
  bit          dropped;
  int unsigned rails;
  bit          decrypt;
  codec_beat_t pending_out[$];
  int unsigned mismatches;

  function new();
    held       = 0;
    dropped    = 0;
    rails      = 1;
    decrypt    = 0;
    mismatches = 0;
  endfunction

  function void set_register(logic [0:0] idx, logic [6:0] val);
    if (idx == ctc_pkg::CFG_RAIL_COUNT) begin
      rails = 32'(val);
    end else begin
      decrypt = val[0];
    end
  endfunction

  function void transpose_message();
    logic [7:0]  arranged [MSG_DEPTH];
    int unsigned nrows, ncols, k, idx;
    codec_beat_t beat;
    nrows = (rails == 0) ? 1 : rails;
    ncols = (held + nrows - 1) / nrows;
    k = 0;
    for (int unsigned r = 0; r < nrows && k < held; r++) begin
      for (int unsigned c = 0; c < ncols; c++) begin
        idx = c * nrows + r;
        if (idx < held) begin
          if (decrypt) begin
            arranged[idx] = msg_buf[k];
          end else begin
            arranged[k] = msg_buf[idx];
          end
          k++;
        end
      end
    end
    for (int unsigned i = 0; i < held; i++) begin
      beat.data = arranged[i];
      beat.last = (i + 1 == held);
      beat.ovf  = dropped;
      pending_out.push_back(beat);
    end
    held    = 0;
    dropped = 0;
  endfunction

  function void note_byte(logic [7:0] data, logic eom);
    if (held < MSG_DEPTH) begin
      msg_buf[held] = data;
      held++;
    end else begin
      dropped = 1;
    end
    if (eom) transpose_message();
  endfunction

  function void check_output(logic [7:0] data, logic last, logic ovf);
    codec_beat_t want;
    if (pending_out.size() == 0) begin
      $display("%0t: unexpected beat: byte %02h last %0b overflow %0b",
               $time, data, last, ovf);
      mismatches++;
      return;
    end
    want = pending_out.pop_front();
    if (want.data !== data) begin
      $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
      mismatches++;
    end
    if (want.last !== last) begin
      $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
      mismatches++;
    end
    if (want.ovf !== ovf) begin
      $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, ovf);
      mismatches++;
    end
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT = 300000;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_we_i         = 1'b0;
  logic [0:0]             cfg_index_i      = ctc_pkg::CFG_RAIL_COUNT;
  logic [ctc_pkg::RW-1:0] cfg_wdata_i      = '0;
  logic                   in_valid_i       = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i      = '0;
  logic                   end_of_message_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i      = 1'b0;
  logic [7:0]             out_byte_o;
  logic                   out_last_o;
  logic                   overflow_o;

  transposition_checker sb = new();

  int cycle_count  = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int stall_style  = 0;
  int stall_hold   = 0;
  int random_bytes = 0;

  columnar_transposition_codec #(
    .MAX_LEN (MSG_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .out_last_o       (out_last_o),
    .overflow_o       (overflow_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // beat monitor for both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i, end_of_message_i);
      if (out_valid_o && out_ready_i) sb.check_output(out_byte_o, out_last_o, overflow_o);
    end
  end

  // receiver: stall style is redrawn each time a random hold count runs out
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_hold  <= $urandom_range(20, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_style)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (cycle_count % 4 == 3);
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic push_byte(input logic [7:0] b, input logic eom);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_out.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic program_codec(input logic [ctc_pkg::RW-1:0] rails, input logic decrypt);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ctc_pkg::CFG_RAIL_COUNT;
    cfg_wdata_i <= rails;
    @(posedge clk_i);
    sb.set_register(ctc_pkg::CFG_RAIL_COUNT, rails);
    cfg_index_i <= ctc_pkg::CFG_DECRYPT_MODE;
    cfg_wdata_i <= {{(ctc_pkg::RW-1){1'b0}}, decrypt};
    @(posedge clk_i);
    sb.set_register(ctc_pkg::CFG_DECRYPT_MODE, {{(ctc_pkg::RW-1){1'b0}}, decrypt});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int                     phase;
    int                     nmsg;
    int                     len;
    logic [ctc_pkg::RW-1:0] rails;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: one row, encrypt
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);
    // zero rows acts as one
    program_codec(7'd0, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    // uneven last column, both directions
    program_codec(7'd3, 1'b0);
    send_message(7);
    program_codec(7'd3, 1'b1);
    send_message(7);
    // more rows than bytes
    program_codec(7'd127, 1'b1);
    send_message(3);
    program_codec(7'd2, 1'b0);
    push_byte(8'h7E, 1'b1);

    phase = 0;
    while (random_bytes < 220) begin
      case (phase)
        0: rails = 7'd64;
        1: rails = 7'd1;
        2: rails = 7'd0;
        3: rails = 7'd127;
        default: begin
          case ($urandom_range(0, 3))
            0, 1: rails = ctc_pkg::RW'($urandom_range(2, 8));
            2: rails = ctc_pkg::RW'($urandom_range(1, 64));
            default: rails = ctc_pkg::RW'($urandom_range(0, 127));
          endcase
        end
      endcase
      program_codec(rails, 1'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 3) != 0);
      nmsg = $urandom_range(1, 4);
      for (int m = 0; m < nmsg; m++) begin
        case ($urandom_range(0, 11))
          0: len = $urandom_range(65, 72);   // overflow, bytes past MSG_DEPTH dropped
          1: len = MSG_DEPTH;
          default: len = $urandom_range(1, 24);
        endcase
        send_message(len);
        random_bytes += len;
        if ($urandom_range(0, 7) == 0) drain();
      end
      phase++;
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_out.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
